@@ src/rpfa_pkg.sv @@
package rpfa_pkg;

    // sizing defaults
    localparam int NUM_FRAMES_DEF = 4096;
    localparam int PAGE_SHIFT_DEF = 12;

    // field widths fixed by the interface
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int PID_W    = 16;
    localparam int TICK_W   = 32;
    localparam int STATUS_W = 3;
    localparam int FRAME_W  = 12;
    localparam int REFS_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 13;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INCR    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DECR    = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_FREE    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_ADDR   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_STALE      = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW   = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_STACK_FULL = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_FRAME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_FRAME = 2'd2;

    localparam logic [CFG_W-1:0] TOP_FRAME_RST = 13'd4096;
    localparam logic [REFS_W-1:0] REFS_MAX     = 8'd255;

    // one frame table entry
    typedef struct packed {
        logic              alloc;
        logic [PID_W-1:0]  owner;
        logic [TICK_W-1:0] stamp;
        logic [REFS_W-1:0] refs;
    } entry_t;

    localparam entry_t ENTRY_RST = '{
        alloc: 1'b0,
        owner: '1,
        stamp: '0,
        refs:  '0
    };

endpackage

@@ src/refcounted_page_frame_allocator.sv @@
// a request is accepted in idle and its result is registered in the execute state, once the
// result register is free or being drained; no new request is accepted until then, due to the
// single read-modify-write of the frame table (read on accept, update and write back in execute)
// reset: asynchronous, active low; afterwards a clearing pass rewrites every table entry
// with in_ready low, then the free stack starts empty
module refcounted_page_frame_allocator #(
    parameter int NUM_FRAMES = rpfa_pkg::NUM_FRAMES_DEF,
    parameter int PAGE_SHIFT = rpfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration write port
    input  logic                              cfg_write,
    input  logic [rpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpfa_pkg::CFG_W-1:0]        cfg_data,

    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rpfa_pkg::KIND_W-1:0]       kind,
    input  logic [rpfa_pkg::ADDR_W-1:0]       address,
    input  logic signed [rpfa_pkg::PID_W-1:0] owner_pid,
    input  logic [rpfa_pkg::TICK_W-1:0]       tick,

    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rpfa_pkg::STATUS_W-1:0]     status,
    output logic [rpfa_pkg::FRAME_W-1:0]      frame,
    output logic [rpfa_pkg::REFS_W-1:0]       count_after,
    output logic                              released
);

    // frame index and free count widths
    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(NUM_FRAMES);
    localparam logic [FW-1:0] LAST_IDX   = FW'(NUM_FRAMES - 1);
    localparam logic [31:0]   OFFSET_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;

    // sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [FW-1:0] clr_idx_reg, clr_idx_next;
    logic [CW-1:0] free_count_reg, free_count_next;

    // configuration registers
    logic                       run_mode_reg;
    logic [rpfa_pkg::CFG_W-1:0] low_frame_reg;
    logic [rpfa_pkg::CFG_W-1:0] top_frame_reg;

    // memories: frame table and free stack
    rpfa_pkg::entry_t table_mem [NUM_FRAMES];
    logic [FW-1:0]    stack_mem [NUM_FRAMES];

    rpfa_pkg::entry_t tbl_rdata_reg;
    logic [FW-1:0]    stk_rdata_reg;

    // request captured on accept
    logic [rpfa_pkg::KIND_W-1:0]  req_kind_reg;
    logic [FW-1:0]                req_idx_reg;
    logic [rpfa_pkg::FRAME_W-1:0] req_frame_reg;
    logic                         req_range_bad_reg;
    logic                         req_rel_bad_reg;
    logic [rpfa_pkg::PID_W-1:0]   req_pid_reg;
    logic [rpfa_pkg::TICK_W-1:0]  req_tick_reg;

    // result register
    logic                          out_valid_reg;
    logic [rpfa_pkg::STATUS_W-1:0] status_reg;
    logic [rpfa_pkg::FRAME_W-1:0]  frame_reg;
    logic [rpfa_pkg::REFS_W-1:0]   count_reg;
    logic                          released_reg;

    // accept side decode
    logic        accept;
    logic [31:0] addr_fr;
    logic        addr_aligned;
    logic        range_bad;
    logic        rel_bad;
    logic [FW-1:0] pop_idx;

    // execute side
    logic                          exec_go;
    logic [rpfa_pkg::STATUS_W-1:0] res_status;
    logic [rpfa_pkg::FRAME_W-1:0]  res_frame;
    logic [rpfa_pkg::REFS_W-1:0]   res_count;
    logic                          res_released;
    logic                          do_push;
    logic                          do_pop;
    logic                          tbl_we;
    logic [FW-1:0]                 tbl_waddr;
    rpfa_pkg::entry_t              tbl_wdata;
    logic [31:0]                   popped_wide;
    logic [rpfa_pkg::REFS_W-1:0]   r;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // frame number and address checks, done before the table read
    assign addr_fr      = address >> PAGE_SHIFT;
    assign addr_aligned = ((address & OFFSET_MASK) == 32'd0);
    assign range_bad    = (addr_fr >= 32'(top_frame_reg)) || (addr_fr >= 32'(NUM_FRAMES));
    assign rel_bad      = !addr_aligned || (addr_fr < 32'(low_frame_reg));
    assign pop_idx      = FW'(free_count_reg - CW'(1));

    // execute waits until the result register is free or being drained
    assign exec_go = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    assign popped_wide = 32'(stk_rdata_reg);
    assign r           = tbl_rdata_reg.refs;

    // update of the entry and the stack for the request in hand
    always_comb
    begin
        res_status   = rpfa_pkg::STAT_OK;
        res_frame    = req_frame_reg;
        res_count    = r;
        res_released = 1'b0;
        do_push      = 1'b0;
        do_pop       = 1'b0;
        tbl_we       = 1'b0;
        tbl_waddr    = req_idx_reg;
        tbl_wdata    = tbl_rdata_reg;

        if (state_reg == ST_CLEAR)
        begin
            // reset sweep of the frame table
            tbl_we    = 1'b1;
            tbl_waddr = clr_idx_reg;
            tbl_wdata = rpfa_pkg::ENTRY_RST;
        end
        else if (req_kind_reg == rpfa_pkg::KIND_ALLOC)
        begin
            if (free_count_reg == '0)
            begin
                res_status = rpfa_pkg::STAT_NO_FREE;
                res_frame  = '0;
                res_count  = '0;
            end
            else
            begin
                // top of stack becomes the new frame, entry fully rewritten
                do_pop          = 1'b1;
                res_frame       = popped_wide[rpfa_pkg::FRAME_W-1:0];
                res_count       = rpfa_pkg::REFS_W'(1);
                tbl_we          = 1'b1;
                tbl_waddr       = stk_rdata_reg;
                tbl_wdata.alloc = 1'b1;
                tbl_wdata.refs  = rpfa_pkg::REFS_W'(1);
                tbl_wdata.owner = run_mode_reg ? req_pid_reg : '1;
                tbl_wdata.stamp = run_mode_reg ? req_tick_reg : '0;
            end
        end
        else if (req_range_bad_reg)
        begin
            res_status = rpfa_pkg::STAT_BAD_ADDR;
            res_count  = '0;
        end
        else
        begin
            // classify: keep going with a count change, or free the frame
            logic free_it;
            free_it = 1'b0;
            unique case (req_kind_reg)
                rpfa_pkg::KIND_RELEASE:
                begin
                    if (req_rel_bad_reg)
                    begin
                        res_status = rpfa_pkg::STAT_BAD_ADDR;
                        res_count  = '0;
                    end
                    else if (tbl_rdata_reg.alloc)
                    begin
                        if (r == '0)
                            res_status = rpfa_pkg::STAT_UNDERFLOW;
                        else if (r > rpfa_pkg::REFS_W'(1))
                        begin
                            tbl_we         = 1'b1;
                            tbl_wdata.refs = r - rpfa_pkg::REFS_W'(1);
                            res_count      = r - rpfa_pkg::REFS_W'(1);
                        end
                        else
                            free_it = 1'b1;
                    end
                    else if (r != '0)
                        res_status = rpfa_pkg::STAT_STALE;
                    else
                        free_it = 1'b1;    // double release pushes again
                end
                rpfa_pkg::KIND_INCR:
                begin
                    if (r == rpfa_pkg::REFS_MAX)
                        res_status = rpfa_pkg::STAT_OVERFLOW;
                    else
                    begin
                        tbl_we         = 1'b1;
                        tbl_wdata.refs = r + rpfa_pkg::REFS_W'(1);
                        res_count      = r + rpfa_pkg::REFS_W'(1);
                    end
                end
                rpfa_pkg::KIND_DECR:
                begin
                    if (r == '0)
                        res_status = rpfa_pkg::STAT_UNDERFLOW;
                    else if (r > rpfa_pkg::REFS_W'(1))
                    begin
                        tbl_we         = 1'b1;
                        tbl_wdata.refs = r - rpfa_pkg::REFS_W'(1);
                        res_count      = r - rpfa_pkg::REFS_W'(1);
                    end
                    else if (req_rel_bad_reg)
                    begin
                        res_status = rpfa_pkg::STAT_BAD_ADDR;
                        res_count  = '0;
                    end
                    else
                        free_it = 1'b1;
                end
                default:
                begin
                    res_status = rpfa_pkg::STAT_OK;    // allocate handled above
                end
            endcase

            if (free_it)
            begin
                if (free_count_reg >= FULL_COUNT)
                    res_status = rpfa_pkg::STAT_STACK_FULL;
                else
                begin
                    tbl_we       = 1'b1;
                    tbl_wdata    = rpfa_pkg::ENTRY_RST;
                    do_push      = 1'b1;
                    res_count    = '0;
                    res_released = 1'b1;
                end
            end
        end

        // table and stack only change in the execute cycle or the sweep
        if (state_reg != ST_CLEAR && !exec_go)
        begin
            tbl_we  = 1'b0;
            do_push = 1'b0;
            do_pop  = 1'b0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        free_count_next = free_count_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + FW'(1);
                if (clr_idx_reg == LAST_IDX)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (do_push)
            free_count_next = free_count_reg + CW'(1);
        else if (do_pop)
            free_count_next = free_count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            free_count_reg <= '0;
            run_mode_reg   <= 1'b0;
            low_frame_reg  <= '0;
            top_frame_reg  <= rpfa_pkg::TOP_FRAME_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            free_count_reg <= free_count_next;

            if (cfg_write)
            begin
                priority case (cfg_index)
                    rpfa_pkg::CFG_RUN_MODE:  run_mode_reg  <= cfg_data[0];
                    rpfa_pkg::CFG_LOW_FRAME: low_frame_reg <= cfg_data;
                    rpfa_pkg::CFG_TOP_FRAME: top_frame_reg <= cfg_data;
                    default:                 run_mode_reg  <= run_mode_reg;
                endcase
            end

            if (exec_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_kind_reg      <= kind;
            req_idx_reg       <= addr_fr[FW-1:0];
            req_frame_reg     <= addr_fr[rpfa_pkg::FRAME_W-1:0];
            req_range_bad_reg <= range_bad;
            req_rel_bad_reg   <= rel_bad;
            req_pid_reg       <= owner_pid;
            req_tick_reg      <= tick;
        end
        if (exec_go)
        begin
            status_reg   <= res_status;
            frame_reg    <= res_frame;
            count_reg    <= res_count;
            released_reg <= res_released;
        end
    end

    // frame table: one read on accept, one write per cycle
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            table_mem[tbl_waddr] <= tbl_wdata;
        if (accept)
            tbl_rdata_reg <= table_mem[addr_fr[FW-1:0]];
    end

    // free stack: top read on accept, push written in execute
    always_ff @(posedge clk)
    begin
        if (do_push)
            stack_mem[free_count_reg[FW-1:0]] <= req_idx_reg;
        if (accept)
            stk_rdata_reg <= stack_mem[pop_idx];
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign frame       = frame_reg;
    assign count_after = count_reg;
    assign released    = released_reg;

endmodule

@@ tb/tb_refcounted_page_frame_allocator.sv @@
module tb_refcounted_page_frame_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    import rpfa_pkg::*;

    // generous bound on the whole run, clearing pass included
    localparam int CYCLE_LIMIT = 1000000;
    localparam int POOL_SPAN   = 12;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
        logic [PID_W-1:0]  owner_pid;
        logic [TICK_W-1:0] tick;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame;
        logic [REFS_W-1:0]   count_after;
        logic                released;
    } result_t;

    // block ports
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [KIND_W-1:0]        kind = '0;
    logic [ADDR_W-1:0]        address = '0;
    logic signed [PID_W-1:0]  owner_pid = '0;
    logic [TICK_W-1:0]        tick = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [STATUS_W-1:0]      status;
    logic [FRAME_W-1:0]       frame;
    logic [REFS_W-1:0]        count_after;
    logic                     released;

    // requests waiting for the driver, results waiting for the block
    request_t pending_requests[$];
    result_t  expected_results[$];

    // shadow of the allocator: free stack and frame table
    logic [FRAME_W-1:0] stack_mem [NUM_FRAMES_DEF];
    int unsigned        stack_depth;
    bit                 frame_in_use [NUM_FRAMES_DEF];
    logic [PID_W-1:0]   frame_pid [NUM_FRAMES_DEF];
    logic [TICK_W-1:0]  frame_tick [NUM_FRAMES_DEF];
    logic [REFS_W-1:0]  frame_count [NUM_FRAMES_DEF];

    // shadow of the registers
    bit          cfg_run;
    int unsigned cfg_low;
    int unsigned cfg_top;

    // driver, receiver and bookkeeping
    request_t    cur_req;
    request_t    seen_req;
    result_t     want;
    logic        req_taken = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          ready_hold = 0;
    int          ready_style = 0;
    int          ready_phase = 0;
    logic [31:0] ready_mask = '1;
    int          cycle_count = 0;
    int          fail_count = 0;
    int          requests_taken = 0;
    int          settings_used = 0;
    int          status_seen [8];

    refcounted_page_frame_allocator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .address     (address),
        .owner_pid   (owner_pid),
        .tick        (tick),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .frame       (frame),
        .count_after (count_after),
        .released    (released)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // put a frame back on the free stack and wipe its table entry
    function automatic void free_frame(int unsigned fn);
        frame_in_use[fn] = 1'b0;
        frame_pid[fn]    = '1;
        frame_tick[fn]   = '0;
        frame_count[fn]  = '0;
        stack_mem[stack_depth] = FRAME_W'(fn);
        stack_depth++;
    endfunction

    // next state of the allocator and the result of one request
    function automatic result_t apply_request(request_t rq);
        result_t     res;
        int unsigned fn;
        int unsigned cnt;
        bit          aligned;
        res = '{status: STAT_OK, frame: '0, count_after: '0, released: 1'b0};
        if (rq.kind == KIND_ALLOC)
        begin
            if (stack_depth == 0)
            begin
                res.status = STAT_NO_FREE;
                return res;
            end
            stack_depth--;
            fn = stack_mem[stack_depth];
            frame_in_use[fn] = 1'b1;
            frame_count[fn]  = 8'd1;
            frame_pid[fn]    = cfg_run ? rq.owner_pid : '1;
            frame_tick[fn]   = cfg_run ? rq.tick : '0;
            res.frame       = FRAME_W'(fn);
            res.count_after = 8'd1;
            return res;
        end
        fn = rq.address >> PAGE_SHIFT_DEF;
        aligned = (rq.address[PAGE_SHIFT_DEF-1:0] == '0);
        res.frame = FRAME_W'(fn);
        // beyond the top of memory: count reads as zero
        if (fn >= cfg_top || fn >= NUM_FRAMES_DEF)
        begin
            res.status = STAT_BAD_ADDR;
            return res;
        end
        cnt = frame_count[fn];
        res.count_after = REFS_W'(cnt);
        case (rq.kind)
            KIND_RELEASE:
            begin
                if (!aligned || fn < cfg_low)
                begin
                    res.status      = STAT_BAD_ADDR;
                    res.count_after = '0;
                    return res;
                end
                if (frame_in_use[fn])
                begin
                    if (cnt == 0)
                    begin
                        res.status = STAT_UNDERFLOW;
                        return res;
                    end
                    if (cnt > 1)
                    begin
                        frame_count[fn] = REFS_W'(cnt - 1);
                        res.count_after = REFS_W'(cnt - 1);
                        return res;
                    end
                end
                else if (cnt != 0)
                begin
                    res.status = STAT_STALE;
                    return res;
                end
            end
            KIND_INCR:
            begin
                if (cnt >= REFS_MAX)
                    res.status = STAT_OVERFLOW;
                else
                begin
                    frame_count[fn] = REFS_W'(cnt + 1);
                    res.count_after = REFS_W'(cnt + 1);
                end
                return res;
            end
            default:
            begin
                if (cnt == 0)
                begin
                    res.status = STAT_UNDERFLOW;
                    return res;
                end
                if (cnt > 1)
                begin
                    frame_count[fn] = REFS_W'(cnt - 1);
                    res.count_after = REFS_W'(cnt - 1);
                    return res;
                end
                // last reference gone: the address must be good enough to free
                if (!aligned || fn < cfg_low)
                begin
                    res.status      = STAT_BAD_ADDR;
                    res.count_after = '0;
                    return res;
                end
            end
        endcase
        if (stack_depth >= NUM_FRAMES_DEF)
        begin
            res.status = STAT_STACK_FULL;
            return res;
        end
        free_frame(fn);
        res.count_after = '0;
        res.released    = 1'b1;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] got);
        if (got !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got);
            fail_count++;
        end
    endfunction

    task automatic queue_req(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                             input logic [PID_W-1:0] p, input logic [TICK_W-1:0] t);
        pending_requests.push_back('{k, a, p, t});
    endtask

    // mostly frames from a small window so that requests meet each other,
    // now and then a wild address anywhere in the 32-bit space
    function automatic request_t random_request(int unsigned pool_lo);
        request_t    rq;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            rq.kind = KIND_ALLOC;
        else if (pick < 55)
            rq.kind = KIND_RELEASE;
        else if (pick < 80)
            rq.kind = KIND_INCR;
        else
            rq.kind = KIND_DECR;
        if ($urandom_range(0, 99) < 85)
            rq.address = {20'(pool_lo + $urandom_range(0, POOL_SPAN - 1)),
                          ($urandom_range(0, 99) < 85) ? 12'h000 : 12'($urandom())};
        else
            rq.address = $urandom();
        rq.owner_pid = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 32767));
        rq.tick = $urandom();
        return rq;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        case (idx)
            CFG_RUN_MODE:  cfg_run = value[0];
            CFG_LOW_FRAME: cfg_low = value & 32'h1FFF;
            CFG_TOP_FRAME: cfg_top = value & 32'h1FFF;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_config(input int unsigned run, input int unsigned low,
                              input int unsigned top);
        write_reg(CFG_RUN_MODE, run);
        write_reg(CFG_LOW_FRAME, low);
        write_reg(CFG_TOP_FRAME, top);
        settings_used++;
    endtask

    // every request sent and every result back, then a short settle;
    // checked at the rising edge where the driver's outputs are settled
    task automatic wait_idle();
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // request driver: bursts of back-to-back requests with random gaps
    always @(negedge clk)
    begin
        if (!in_valid || req_taken)
        begin
            if (gap_left != 0 || pending_requests.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left != 0)
                    gap_left--;
            end
            else
            begin
                cur_req = pending_requests.pop_front();
                kind      <= cur_req.kind;
                address   <= cur_req.address;
                owner_pid <= cur_req.owner_pid;
                tick      <= cur_req.tick;
                in_valid  <= 1'b1;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 24);
                burst_left--;
                // a third of the bursts run straight into the next one
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
    end

    // result receiver: ready is held high or follows a random bit mask, redrawn when its hold count runs out
    always @(negedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_hold  = $urandom_range(50, 300);
            ready_style = $urandom_range(0, 2);
            ready_mask  = (ready_style == 2) ? ($urandom() & $urandom()) : $urandom();
            // never a window that holds results forever
            ready_mask[0] = 1'b1;
        end
        ready_hold--;
        ready_phase++;
        out_ready <= (ready_style == 0) ? 1'b1 : ready_mask[ready_phase % 32];
    end

    // monitor: check results against the oldest expectation, then predict
    // for the request taken at this same edge
    always @(posedge clk)
    begin
        req_taken <= in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding: status %0d frame %0d",
                       status, frame);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", want.status, status);
                check_field("frame", want.frame, frame);
                check_field("count_after", want.count_after, count_after);
                check_field("released", want.released, released);
                status_seen[want.status]++;
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            seen_req.kind      = kind;
            seen_req.address   = address;
            seen_req.owner_pid = owner_pid;
            seen_req.tick      = tick;
            expected_results.push_back(apply_request(seen_req));
            requests_taken++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        // phase table: run mode, low frame, top frame, window base, random count
        int unsigned ph_run [6] = '{1, 0, 1, 0, 1, 0};
        int unsigned ph_low [6] = '{0, 20, 4090, 4096, 0, 8};
        int unsigned ph_top [6] = '{4096, 26, 4096, 4096, 0, 4096};
        int unsigned ph_pool [6] = '{0, 16, 4084, 0, 0, 0};
        int unsigned ph_count [6] = '{300, 250, 250, 150, 100, 400};
        int          spare_a;
        int          spare_b;
        int          fill;

        // shadow state after reset
        stack_depth = 0;
        for (int i = 0; i < NUM_FRAMES_DEF; i++)
        begin
            stack_mem[i]    = '0;
            frame_in_use[i] = 1'b0;
            frame_pid[i]    = '1;
            frame_tick[i]   = '0;
            frame_count[i]  = '0;
        end
        foreach (status_seen[i])
            status_seen[i] = 0;
        cfg_run = 1'b0;
        cfg_low = 0;
        cfg_top = TOP_FRAME_RST;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // table clearing pass after reset holds in_ready low
        while (in_ready !== 1'b1)
            @(negedge clk);

        for (int p = 0; p < 6; p++)
        begin
            wait_idle();
            set_config(ph_run[p], ph_low[p], ph_top[p]);
            if (p == 0)
            begin
                // allocate from an empty stack
                queue_req(KIND_ALLOC, 32'h0000_0000, 16'h7FFF, 32'hFFFF_FFFF);
                // free frames 5 and 6, then take 6 back with no owner at tick 0
                queue_req(KIND_RELEASE, 32'h0000_5000, 16'h0001, 32'h0000_0001);
                queue_req(KIND_RELEASE, 32'h0000_6000, 16'hFFFF, 32'h0000_0002);
                queue_req(KIND_ALLOC, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000);
                // share it: the offset bits are ignored here
                queue_req(KIND_INCR, 32'h0000_6ABC, 16'h0000, 32'h0000_0003);
                queue_req(KIND_RELEASE, 32'h0000_6000, 16'h0000, 32'h0000_0004);
                queue_req(KIND_RELEASE, 32'h0000_6000, 16'h0000, 32'h0000_0005);
                // decrement of a zero count
                queue_req(KIND_DECR, 32'h0000_7000, 16'h0002, 32'h0000_0006);
                // count on a frame that is not allocated: release sees a stale count
                queue_req(KIND_INCR, 32'h0000_7000, 16'h0002, 32'h0000_0007);
                queue_req(KIND_RELEASE, 32'h0000_7000, 16'h0002, 32'h0000_0008);
                // last reference through an unaligned address, then aligned
                queue_req(KIND_DECR, 32'h0000_7004, 16'h0003, 32'h0000_0009);
                queue_req(KIND_DECR, 32'h0000_7000, 16'h0003, 32'h0000_000A);
                // addresses beyond memory and unaligned release
                queue_req(KIND_RELEASE, 32'hFFFF_FFFF, 16'h7FFF, 32'h8000_0000);
                queue_req(KIND_INCR, 32'h0100_0000, 16'h7FFF, 32'h8000_0001);
                queue_req(KIND_DECR, 32'h0100_0000, 16'h7FFF, 32'h8000_0002);
                queue_req(KIND_RELEASE, 32'h0000_5001, 16'h0004, 32'h0000_000B);
                // lowest and highest frame
                queue_req(KIND_RELEASE, 32'h0000_0000, 16'h0005, 32'h0000_000C);
                queue_req(KIND_RELEASE, 32'h00FF_F000, 16'h0005, 32'h0000_000D);
                queue_req(KIND_ALLOC, 32'h0000_0000, 16'h0006, 32'h7FFF_FFFF);
                queue_req(KIND_ALLOC, 32'h0000_0000, 16'h0007, 32'h1234_5678);
                queue_req(KIND_DECR, 32'h00FF_F000, 16'h0008, 32'h0000_000E);
                queue_req(KIND_DECR, 32'h00FF_FFFF, 16'h0008, 32'h0000_000F);
                queue_req(KIND_ALLOC, 32'h0000_0000, 16'h0009, 32'h0000_0010);
                // push frame 100 to the count ceiling and one past it
                repeat (256)
                    queue_req(KIND_INCR, 32'h0006_4000, 16'h000A, $urandom());
                queue_req(KIND_RELEASE, 32'h0006_4000, 16'h000A, 32'h0000_0011);
            end
            repeat (ph_count[p])
                pending_requests.push_back(random_request(ph_pool[p]));
        end

        // fill the free stack to the brim by releasing one free frame over and over
        wait_idle();
        set_config(1, 0, 4096);
        spare_a = -1;
        spare_b = -1;
        for (int i = 0; i < NUM_FRAMES_DEF; i++)
        begin
            if (!frame_in_use[i] && frame_count[i] == 0)
            begin
                if (spare_a < 0)
                    spare_a = i;
                else if (spare_b < 0)
                    spare_b = i;
            end
        end
        if (spare_a >= 0 && spare_b >= 0 && stack_depth < NUM_FRAMES_DEF)
        begin
            // spare_a ends up allocated with a single reference
            queue_req(KIND_RELEASE, 32'(spare_a) << PAGE_SHIFT_DEF, 16'h0100, $urandom());
            queue_req(KIND_ALLOC, 32'h0000_0000, 16'h0100, $urandom());
            fill = NUM_FRAMES_DEF - stack_depth;
            repeat (fill)
                queue_req(KIND_RELEASE, 32'(spare_b) << PAGE_SHIFT_DEF, 16'h0101, $urandom());
            // every push now bounces off the full stack
            queue_req(KIND_RELEASE, 32'(spare_b) << PAGE_SHIFT_DEF, 16'h0101, $urandom());
            queue_req(KIND_DECR, 32'(spare_a) << PAGE_SHIFT_DEF, 16'h0102, $urandom());
            queue_req(KIND_RELEASE, 32'(spare_a) << PAGE_SHIFT_DEF, 16'h0102, $urandom());
            // a release that only drops a reference does not need room
            queue_req(KIND_INCR, 32'(spare_a) << PAGE_SHIFT_DEF, 16'h0103, $urandom());
            queue_req(KIND_RELEASE, 32'(spare_a) << PAGE_SHIFT_DEF, 16'h0103, $urandom());
            // make room and push once more
            queue_req(KIND_ALLOC, 32'h0000_0000, 16'h0104, $urandom());
            queue_req(KIND_RELEASE, 32'(spare_b) << PAGE_SHIFT_DEF, 16'h0104, $urandom());
        end

        wait_idle();
        repeat (16) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end

        $display("covered %0d requests over %0d register settings, %0d failures",
                 requests_taken, settings_used, fail_count);
        $display("status mix: ok %0d, no free %0d, bad address %0d, underflow %0d,",
                 status_seen[STAT_OK], status_seen[STAT_NO_FREE],
                 status_seen[STAT_BAD_ADDR], status_seen[STAT_UNDERFLOW]);
        $display("            stale %0d, overflow %0d, stack full %0d",
                 status_seen[STAT_STALE], status_seen[STAT_OVERFLOW],
                 status_seen[STAT_STACK_FULL]);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/rpfa_pkg.sv
src/refcounted_page_frame_allocator.sv
tb/tb_refcounted_page_frame_allocator.sv
